// File: sv/ksrs_pkg.sv
// ----------------------------------------------------------------------------
// ksrs_pkg - shared definitions for the keyed SplitMix64 random stream
// Constants of the SplitMix64 finaliser, the pre-mixed tags, the controller
// state encoding and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package ksrs_pkg;

    // SplitMix64 constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam logic [63:0] STREAM_TAG   = 64'h534550524e474b59;

    // Field widths of the stream items
    localparam int WORD_W    = 64;
    localparam int UNI_W     = 53;
    localparam int UNI_SHIFT = WORD_W - UNI_W;
    localparam int KEY_NUM   = 4;

    // Finaliser evaluated at elaboration only, to fold the fixed tags
    function automatic logic [63:0] mix64_const(input logic [63:0] v);
        logic [63:0] x;
        begin
            x = v + GOLDEN_GAMMA;
            x = (x ^ (x >> 30)) * MIX_MUL_A;
            x = (x ^ (x >> 27)) * MIX_MUL_B;
            return x ^ (x >> 31);
        end
    endfunction

    // Stream state after reset, and key working state at the start of every key item
    localparam logic [63:0] MIX_TAG = mix64_const(STREAM_TAG);

    // Mixed key-field tags 1..4, indexed from 0
    localparam logic [63:0] MIX_KEY [KEY_NUM] = '{
        mix64_const(64'd1), mix64_const(64'd2),
        mix64_const(64'd3), mix64_const(64'd4)
    };

    // Controller states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_ADV  = 11'b000_0000_0010,
        ST_LOAD = 11'b000_0000_0100,
        ST_MA0  = 11'b000_0000_1000,
        ST_MA1  = 11'b000_0001_0000,
        ST_MA2  = 11'b000_0010_0000,
        ST_X27  = 11'b000_0100_0000,
        ST_MB0  = 11'b000_1000_0000,
        ST_MB1  = 11'b001_0000_0000,
        ST_MB2  = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } ksrs_state_t;

    // Which value enters the mix unit (also the current phase of an item)
    typedef enum logic [1:0] {
        SRC_FIELD  = 2'd0,
        SRC_ABSORB = 2'd1,
        SRC_DRAW   = 2'd2
    } ksrs_src_t;

    // Partial product selected for the shared 32x32 multiplier
    typedef enum logic [1:0] {
        PART_LO = 2'd0,
        PART_HX = 2'd1,
        PART_HC = 2'd2
    } ksrs_part_t;

    typedef struct packed {
        logic       capture;
        logic       key_init;
        logic       advance;
        logic       load;
        ksrs_src_t  src;
        logic [1:0] key_idx;
        logic       mul_en;
        logic       mul_b;
        ksrs_part_t part;
        logic       xs27;
        logic       fin_fld;
        logic       fin_kst;
        logic       fin_state;
        logic       fin_out;
    } ksrs_cmd_t;

    typedef struct packed {
        logic out_free;
    } ksrs_sts_t;

endpackage

// File: sv/keyed_splitmix_random_stream.sv
// ----------------------------------------------------------------------------
// keyed_splitmix_random_stream - keyed SplitMix64 random stream
// Key items set up a stream from seed, particle, operator and event ids;
// draw items return the next 64-bit value and its top 53 bits.
// ----------------------------------------------------------------------------
// A key item (s_tuser = 0) rebuilds the stream state from the seed register
// and the three ids and returns nothing; it occupies the block from its
// acceptance through eight SplitMix64 mixes. A draw item (s_tuser = 1)
// advances the state, mixes it and loads its result into the output
// register once that register is free, and the block takes the next item
// in the cycle after that load. The single 32x32 multiplier forms each
// 64-bit product as three partial products, one per cycle, with two products
// per mix. One item is in work at a time; a finished draw waits in the output
// register while the next item is accepted. A seed write takes effect at the
// next key item. After reset the block draws from the state that the fixed
// stream tag gives.
module keyed_splitmix_random_stream (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,     // campaign_seed
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,       // particle_id, operator_id, event_index
    input  logic [0:0]   s_tuser,       // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata        // draw, uniform_bits, zero padding
);
    import ksrs_pkg::*;

    ksrs_cmd_t cmd;
    ksrs_sts_t sts;

    // Sequencer
    ksrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    ksrs_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sv/ksrs_ctrl.sv
// ----------------------------------------------------------------------------
// ksrs_ctrl - sequencer of the keyed SplitMix64 random stream
// Walks each mix through load, three partial products per multiply and the
// final xor-shift, and chains the eight mixes of a key item.
// ----------------------------------------------------------------------------
module ksrs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_op,
    output logic                  s_tready,
    input  ksrs_pkg::ksrs_sts_t   sts,
    output ksrs_pkg::ksrs_cmd_t   cmd
);
    import ksrs_pkg::*;

    ksrs_state_t state_reg, state_next;
    ksrs_src_t   phase_reg, phase_next;
    logic [1:0]  k_reg, k_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.src       = phase_reg;
        cmd.key_idx   = k_reg;
        cmd.part      = PART_LO;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_op) begin
                        phase_next = SRC_DRAW;
                        state_next = ST_ADV;
                    end else begin
                        cmd.key_init = 1'b1;
                        k_next       = 2'd0;
                        phase_next   = SRC_FIELD;
                        state_next   = ST_LOAD;
                    end
                end
            end
            ST_ADV: begin
                cmd.advance = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MA0;
            end
            ST_MA0: begin
                cmd.mul_en = 1'b1;
                cmd.part   = PART_LO;
                state_next = ST_MA1;
            end
            ST_MA1: begin
                cmd.mul_en = 1'b1;
                cmd.part   = PART_HX;
                state_next = ST_MA2;
            end
            ST_MA2: begin
                cmd.mul_en = 1'b1;
                cmd.part   = PART_HC;
                state_next = ST_X27;
            end
            ST_X27: begin
                cmd.xs27   = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0: begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.part   = PART_LO;
                state_next = ST_MB1;
            end
            ST_MB1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.part   = PART_HX;
                state_next = ST_MB2;
            end
            ST_MB2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
                cmd.part   = PART_HC;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                case (phase_reg)
                    SRC_DRAW: begin
                        // hold the result until the output register is free
                        if (sts.out_free) begin
                            cmd.fin_out = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    SRC_FIELD: begin
                        cmd.fin_fld = 1'b1;
                        phase_next  = SRC_ABSORB;
                        state_next  = ST_LOAD;
                    end
                    SRC_ABSORB: begin
                        cmd.fin_kst = 1'b1;
                        if (k_reg == 2'd3) begin
                            cmd.fin_state = 1'b1;
                            state_next    = ST_IDLE;
                        end else begin
                            k_next     = k_reg + 2'd1;
                            phase_next = SRC_FIELD;
                            state_next = ST_LOAD;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= SRC_DRAW;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

endmodule

// File: sv/ksrs_dpath.sv
// ----------------------------------------------------------------------------
// ksrs_dpath - datapath of the keyed SplitMix64 random stream
// Holds seed, key fields, stream state and the mix work registers; one
// shared 32x32 multiplier builds each 64-bit product from three partials.
// ----------------------------------------------------------------------------
module ksrs_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [63:0]           cfg_wdata,
    input  logic [191:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [119:0]          m_tdata,
    input  ksrs_pkg::ksrs_cmd_t   cmd,
    output ksrs_pkg::ksrs_sts_t   sts
);
    import ksrs_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] part_id_reg, oper_id_reg, event_idx_reg;
    logic [63:0] state_reg;
    logic [63:0] kst_reg;
    logic [63:0] fld_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] draw_reg;
    logic        m_tvalid_reg;

    logic [63:0] src_val;
    logic [63:0] pre_mix;
    logic [63:0] mul_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] fin_r;

    // Select the value entering the mix
    always_comb begin
        case (cmd.src)
            SRC_FIELD: begin
                case (cmd.key_idx)
                    2'd0:    src_val = seed_reg;
                    2'd1:    src_val = part_id_reg;
                    2'd2:    src_val = oper_id_reg;
                    default: src_val = event_idx_reg;
                endcase
            end
            SRC_ABSORB: src_val = kst_reg ^ MIX_KEY[cmd.key_idx] ^ fld_reg;
            SRC_DRAW:   src_val = state_reg;
            default:    src_val = '0;
        endcase
    end

    // Add the increment and apply the first xor-shift
    logic [63:0] pre_sum;
    assign pre_sum = src_val + GOLDEN_GAMMA;
    assign pre_mix = pre_sum ^ (pre_sum >> 30);

    // Shared multiplier operands
    assign mul_c = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
    always_comb begin
        case (cmd.part)
            PART_HX: begin
                mul_a = x_reg[63:32];
                mul_b = mul_c[31:0];
            end
            PART_HC: begin
                mul_a = x_reg[31:0];
                mul_b = mul_c[63:32];
            end
            default: begin
                mul_a = x_reg[31:0];
                mul_b = mul_c[31:0];
            end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // Final xor-shift of the mix
    assign fin_r = acc_reg ^ (acc_reg >> 31);

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    // Capture key fields of an accepted item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            part_id_reg   <= s_tdata[63:0];
            oper_id_reg   <= s_tdata[127:64];
            event_idx_reg <= s_tdata[191:128];
        end
    end

    // Stream state: advance on draw, replace at the end of a key item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MIX_TAG;
        end else if (cmd.advance) begin
            state_reg <= state_reg + GOLDEN_GAMMA;
        end else if (cmd.fin_state) begin
            state_reg <= fin_r;
        end
    end

    // Key working state and mixed field
    always_ff @(posedge aclk) begin
        if (cmd.key_init) begin
            kst_reg <= MIX_TAG;
        end else if (cmd.fin_kst) begin
            kst_reg <= fin_r;
        end
        if (cmd.fin_fld) begin
            fld_reg <= fin_r;
        end
    end

    // Mix operand and product accumulator
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= pre_mix;
        end else if (cmd.xs27) begin
            x_reg <= acc_reg ^ (acc_reg >> 27);
        end
        if (cmd.mul_en) begin
            if (cmd.part == PART_LO) begin
                acc_reg <= prod;
            end else begin
                acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.fin_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.fin_out) begin
            draw_reg <= fin_r;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {3'd0, draw_reg[WORD_W-1:UNI_SHIFT], draw_reg};

endmodule

// File: sv/ksrs_checker.sv
// ----------------------------------------------------------------------------
// ksrs_checker - port-level checks for the keyed SplitMix64 random stream
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ksrs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An accepted item leaves the block busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // A key item never produces a result
    a_key_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result after key item");

    // Uniform bits are the top of the draw, padding is zero
    a_uniform_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[116:64] == m_tdata[63:11] && m_tdata[119:117] == 3'd0)
        else $error("uniform bits mismatch");

    // A new result appears as the block goes free
    a_result_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while busy");

endmodule

bind keyed_splitmix_random_stream ksrs_checker u_ksrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
